/* rtl/mws_pkg.sv */
// Shared types and constants for the moving window sum block.
// No dependencies; imported by every module under rtl/.
package mws_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int TOTAL_W        = 42;
    localparam int CFG_W          = 11;
    localparam int WINDOW_MAX_DEF = 1024;

    // One result beat as it leaves the block
    typedef struct packed {
        logic signed [TOTAL_W-1:0] window_total;
        logic                      total_available;
        logic                      gap_error;
    } t_result;

endpackage

/* rtl/moving_window_sum.sv */
// Top level of the moving window sum: accumulator, gap tracking and config.
// Depends on mws_pkg, mws_delay_line, mws_out_buf.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  input    | i_in_valid / o_in_ready   | i_sample, i_sample_missing
//  output   | o_out_valid / i_out_ready | o_window_total, o_total_available, o_gap_error
//  config   | i_cfg_we (no wait)        | i_cfg_wdata (window length)
//
// One sample beat per cycle while o_in_ready is high; results are registered in
// the output buffer. The rate is set by the combinational running-sum update and the
// one-slot shift of the delay cells; the last cell holds the sample a window back.
// Reset is synchronous and needs no clearing pass; the delay cells hold no reset.
// The output register plus a skid slot keep the input open while one result
// waits; o_in_ready drops only when two results are held.
module moving_window_sum #(
    parameter int WINDOW_MAX = mws_pkg::WINDOW_MAX_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_sample_missing,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mws_pkg::TOTAL_W-1:0]   o_window_total,
    output logic                                 o_total_available,
    output logic                                 o_gap_error,
    input  logic                                 i_cfg_we,
    input  logic [mws_pkg::CFG_W-1:0]            i_cfg_wdata
);
    import mws_pkg::*;

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    logic [LEN_W-1:0]          r_win;
    logic [LEN_W-1:0]          w_cfg_win;
    logic [LEN_W-1:0]          r_seen;
    logic [LEN_W-1:0]          n_seen;
    logic signed [TOTAL_W-1:0] r_total;
    logic signed [TOTAL_W-1:0] n_total;
    logic                      r_err;
    logic                      n_err;
    logic                      w_accept;
    logic                      w_shift;
    logic                      w_full;
    logic                      w_avail;
    logic signed [SAMPLE_W-1:0] w_tail;
    logic signed [TOTAL_W-1:0] w_new_ext;
    logic signed [TOTAL_W-1:0] w_old_ext;
    t_result                   w_res;
    t_result                   w_out;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_full    = (r_seen >= r_win);
    assign w_new_ext = TOTAL_W'(i_sample);
    assign w_old_ext = TOTAL_W'(w_tail);

    // Clamp the written window into 1..WINDOW_MAX
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_win = LEN_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(WINDOW_MAX)) begin
            w_cfg_win = LEN_W'(WINDOW_MAX);
        end else begin
            w_cfg_win = LEN_W'(i_cfg_wdata);
        end
    end

    // Update running sum, warm-up count and gap flag for one beat
    always_comb begin
        n_total = r_total;
        n_seen  = r_seen;
        n_err   = r_err;
        w_shift = 1'b0;
        w_avail = 1'b0;
        if (w_accept && !r_err) begin
            if (i_sample_missing) begin
                if (r_seen != '0) begin
                    n_err = 1'b1;
                end
            end else begin
                w_shift = 1'b1;
                if (w_full) begin
                    n_total = r_total + w_new_ext - w_old_ext;
                    w_avail = 1'b1;
                end else begin
                    n_total = r_total + w_new_ext;
                    n_seen  = r_seen + LEN_W'(1);
                    w_avail = (r_seen + LEN_W'(1) >= r_win);
                end
            end
        end
    end

    // Form the result beat; unavailable totals read as zero
    always_comb begin
        w_res.gap_error       = n_err;
        w_res.total_available = w_avail && !n_err;
        w_res.window_total    = (w_avail && !n_err) ? n_total : '0;
    end

    // State registers; a window write restarts accumulation but keeps the gap flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= LEN_W'(1);
            r_seen  <= '0;
            r_total <= '0;
            r_err   <= 1'b0;
        end else if (i_cfg_we) begin
            r_win   <= w_cfg_win;
            r_seen  <= '0;
            r_total <= '0;
        end else begin
            r_seen  <= n_seen;
            r_total <= n_total;
            r_err   <= n_err;
        end
    end

    mws_delay_line #(
        .WINDOW_MAX (WINDOW_MAX),
        .LEN_W      (LEN_W)
    ) u_delay (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_shift),
        .i_sample (i_sample),
        .i_cfg_we (i_cfg_we),
        .i_win    (w_cfg_win),
        .o_tail   (w_tail)
    );

    mws_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_data     (w_res),
        .o_in_ready (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (w_out)
    );

    assign o_window_total    = w_out.window_total;
    assign o_total_available = w_out.total_available;
    assign o_gap_error       = w_out.gap_error;

    // Gap flag is sticky until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("gap flag cleared without reset");

    // Warm-up count never passes the window
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= r_win)
        else $error("valid sample count above window");

    // An available total never comes with the gap flag
    a_avail_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_total_available |-> !o_gap_error)
        else $error("total marked available with gap flag set");

    // Unavailable totals read as zero
    a_na_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_total_available |-> o_window_total == '0)
        else $error("nonzero total marked unavailable");

endmodule

/* rtl/mws_cell.sv */
// One sample slot of the delay line.
// Depends on mws_pkg for the sample width.
module mws_cell (
    input  logic                                 i_clk,
    input  logic                                 i_shift,
    input  logic                                 i_load_new,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  i_new,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  i_prev,
    output logic signed [mws_pkg::SAMPLE_W-1:0]  o_data
);
    import mws_pkg::*;

    logic signed [SAMPLE_W-1:0] r_data;
    logic signed [SAMPLE_W-1:0] n_data;

    // Take the fresh sample at the entry slot, else the neighbor's
    always_comb begin
        n_data = r_data;
        if (i_shift) begin
            n_data = i_load_new ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/mws_delay_line.sv */
// Variable-length delay line built from a row of mws_cell slots.
// New samples enter at slot WINDOW_MAX - window; the oldest sits at the last slot.
// Depends on mws_pkg and mws_cell.
module mws_delay_line #(
    parameter int WINDOW_MAX = mws_pkg::WINDOW_MAX_DEF,
    parameter int LEN_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic signed [mws_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_cfg_we,
    input  logic [LEN_W-1:0]                     i_win,
    output logic signed [mws_pkg::SAMPLE_W-1:0]  o_tail
);
    import mws_pkg::*;

    logic [WINDOW_MAX-1:0]      r_entry;
    logic [WINDOW_MAX-1:0]      n_entry;
    logic signed [SAMPLE_W-1:0] w_data [WINDOW_MAX];

    // Decode the entry slot for the window being written
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_entry
        assign n_entry[k] = (LEN_W'(WINDOW_MAX - k) == i_win);
    end

    // Hold the entry slot; reset window of one puts it at the last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= {1'b1, {(WINDOW_MAX-1){1'b0}}};
        end else if (i_cfg_we) begin
            r_entry <= n_entry;
        end
    end

    // Row of cells, each fed by its lower neighbor
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        logic signed [SAMPLE_W-1:0] w_prev;
        if (k == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_rest
            assign w_prev = w_data[k-1];
        end
        mws_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_shift),
            .i_load_new (r_entry[k]),
            .i_new      (i_sample),
            .i_prev     (w_prev),
            .o_data     (w_data[k])
        );
    end

    assign o_tail = w_data[WINDOW_MAX-1];

    // Exactly one entry slot at all times
    a_entry_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_entry))
        else $error("delay line entry slot not one-hot");

    // Entry slot moves only on a window write
    a_entry_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cfg_we) && $past(i_rst_n) |-> $stable(r_entry))
        else $error("delay line entry slot moved without a window write");

    // A decoded window always maps to exactly one slot
    a_decode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> $onehot(n_entry))
        else $error("window decode does not hit exactly one slot");

endmodule

/* rtl/mws_out_buf.sv */
// Two-entry output buffer: output register plus a skid slot.
// Depends on mws_pkg for the result type.
module mws_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mws_pkg::t_result i_data,
    output logic             o_in_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output mws_pkg::t_result o_data
);
    import mws_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop      = r_out_vld && i_ready;
    assign o_in_ready = !r_skid_vld;

    // Control: advance skid into output when the output frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || w_pop) begin
            r_out_vld  <= r_skid_vld || i_push;
            r_skid_vld <= 1'b0;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (!r_out_vld || w_pop) begin
            r_out <= r_skid_vld ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Skid slot is only used behind a held output beat
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid slot full while output empty");

    // A held beat with a full skid must not be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_ready |=> r_skid_vld && r_out_vld)
        else $error("output buffer dropped a beat");

    // Nothing is pushed into a full buffer
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_vld)
        else $error("push into full output buffer");

endmodule
